@@ rtl/clsft_pkg.sv @@
// ----------------------------------------------------------------------------
// clsft_pkg: shared types and constants of the CPU load share block
// Holds the sample and result layouts, the controller-to-datapath command and
// status structs, and the fixed constants of the share arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package clsft_pkg;

    // Field widths.
    localparam int CNT_W   = 64;
    localparam int SHARE_W = 10;
    localparam int CFG_W   = 10;
    localparam int SUM_W   = SHARE_W + 2;

    // Share arithmetic: the product 1000 * delta needs 74 bits. The quotient
    // is below 1024, so only its low ten bits are iterated.
    localparam int DIV_STEPS = 10;
    localparam int PROD_W    = CNT_W + DIV_STEPS;
    localparam int NUM_CNT   = 5;

    localparam logic [SHARE_W-1:0] SHARE_SCALE     = 10'd1000;
    localparam logic [CFG_W-1:0]   MIN_TICKS_RESET = 10'd10;

    // Counter lanes in the delta array.
    localparam logic [2:0] LANE_USER   = 3'd0;
    localparam logic [2:0] LANE_NICE   = 3'd1;
    localparam logic [2:0] LANE_SYSTEM = 3'd2;
    localparam logic [2:0] LANE_IDLE   = 3'd3;
    localparam logic [2:0] LANE_IOWAIT = 3'd4;

    // Share slots, in the order they are computed.
    localparam logic [1:0] SHARE_USER   = 2'd0;
    localparam logic [1:0] SHARE_SYSTEM = 2'd1;
    localparam logic [1:0] SHARE_NICE   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] user_count;
        logic [CNT_W-1:0] nice_count;
        logic [CNT_W-1:0] system_count;
        logic [CNT_W-1:0] idle_count;
        logic [CNT_W-1:0] iowait_count;
    } sample_t;

    typedef struct packed {
        logic [SHARE_W-1:0] user_share;
        logic [SHARE_W-1:0] system_share;
        logic [SHARE_W-1:0] nice_share;
        logic [SHARE_W-1:0] idle_share;
        logic               too_few_ticks;
    } share_t;

    typedef struct packed {
        logic       load;       // take the sample, form deltas, clear total
        logic       acc;        // add one delta to the total
        logic [2:0] acc_sel;    // counter lane for acc
        logic       mul;        // form 1000 * delta for one share
        logic [1:0] lane;       // share slot for mul and store
        logic       div_step;   // one restoring division step
        logic       store;      // write the finished share
        logic       emit;       // load the output register
        logic       emit_short; // output the too-few-ticks result
    } dp_cmd_t;

    typedef struct packed {
        logic enough;           // total exceeds the configured minimum
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/clsft_stream_if.sv @@
// ----------------------------------------------------------------------------
// clsft_stream_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsft_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/clsft_ctrl.sv @@
// ----------------------------------------------------------------------------
// clsft_ctrl: sequencing controller
// Walks one item through delta summing, the minimum check, three share divisions
// when it passes, and the output write, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module clsft_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  clsft_pkg::dp_status_t  status,
    output clsft_pkg::dp_cmd_t     cmd
);
    import clsft_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SUM   = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] lane_reg, lane_next;
    logic       short_reg, short_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lane_next  = lane_reg;
        short_next = short_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.lane   = lane_reg;
        cmd.acc_sel = cnt_reg[2:0];
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.acc = 1'b1;
                if (cnt_reg[2:0] == LANE_IOWAIT)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_CHECK:
            begin
                short_next = !status.enough;
                lane_next  = SHARE_USER;
                state_next = status.enough ? S_MUL : S_FIN;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (lane_reg == SHARE_NICE)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                // Wait here only while an earlier result is still not taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_short = short_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            lane_reg      <= '0;
            short_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lane_reg      <= lane_next;
            short_reg     <= short_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/clsft_dpath.sv @@
// ----------------------------------------------------------------------------
// clsft_dpath: counter and share datapath
// Holds the previous counters, the deltas, the total, the configured minimum,
// one shared multiply and restoring divide unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clsft_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  clsft_pkg::sample_t              sample_data,
    output clsft_pkg::share_t               result_data,
    input  logic                            cfg_wr,
    input  logic [clsft_pkg::CFG_W-1:0]     cfg_data,
    input  clsft_pkg::dp_cmd_t              cmd,
    output clsft_pkg::dp_status_t           status
);
    import clsft_pkg::*;

    logic [CNT_W-1:0]   in_cnt [NUM_CNT];
    logic [CNT_W-1:0]   prev_reg [NUM_CNT];
    logic [CNT_W-1:0]   delta_reg [NUM_CNT];
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CFG_W-1:0]   min_reg;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [DIV_STEPS-1:0] low_reg, low_next;
    logic [DIV_STEPS-1:0] quot_reg, quot_next;
    logic               sat_reg, sat_next;
    logic [SHARE_W-1:0] share_reg [3];
    share_t             out_reg, out_next;

    logic [CNT_W-1:0]   mul_delta;
    logic [PROD_W-1:0]  product;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     trial_diff;
    logic               take;
    logic [SHARE_W-1:0] share_val;
    logic [SUM_W-1:0]   share_sum;

    assign in_cnt[LANE_USER]   = sample_data.user_count;
    assign in_cnt[LANE_NICE]   = sample_data.nice_count;
    assign in_cnt[LANE_SYSTEM] = sample_data.system_count;
    assign in_cnt[LANE_IDLE]   = sample_data.idle_count;
    assign in_cnt[LANE_IOWAIT] = sample_data.iowait_count;

    assign status.enough = total_reg > CNT_W'(min_reg);

    // Pick the delta of the share slot being computed.
    always_comb
    begin
        case (cmd.lane)
            SHARE_USER:   mul_delta = delta_reg[LANE_USER];
            SHARE_SYSTEM: mul_delta = delta_reg[LANE_SYSTEM];
            SHARE_NICE:   mul_delta = delta_reg[LANE_NICE];
            default:      mul_delta = delta_reg[LANE_USER];
        endcase
    end

    // 1000 * delta formed as 1024 * delta - 16 * delta - 8 * delta.
    assign product = {mul_delta, 10'b0} - {6'b0, mul_delta, 4'b0} - {7'b0, mul_delta, 3'b0};

    // One restoring step; a carry out of the shifted remainder always subtracts.
    assign trial      = {rem_reg, low_reg[DIV_STEPS-1]};
    assign trial_diff = trial - {1'b0, total_reg};
    assign take       = trial >= {1'b0, total_reg};

    // Saturated share from the finished quotient.
    assign share_val = (sat_reg || (quot_reg > SHARE_SCALE)) ? SHARE_SCALE : quot_reg;

    // Total accumulation and divider registers.
    always_comb
    begin
        total_next = total_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        sat_next   = sat_reg;
        if (cmd.load)
        begin
            total_next = '0;
        end
        else if (cmd.acc)
        begin
            total_next = total_reg + delta_reg[cmd.acc_sel];
        end
        if (cmd.mul)
        begin
            rem_next  = product[PROD_W-1:DIV_STEPS];
            low_next  = product[DIV_STEPS-1:0];
            quot_next = '0;
            sat_next  = mul_delta >= total_reg;
        end
        else if (cmd.div_step)
        begin
            rem_next  = take ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            low_next  = {low_reg[DIV_STEPS-2:0], 1'b0};
            quot_next = {quot_reg[DIV_STEPS-2:0], take};
        end
    end

    // Output item: idle takes what is left of 1000, clamped at zero.
    assign share_sum = SUM_W'(share_reg[SHARE_USER]) + SUM_W'(share_reg[SHARE_SYSTEM])
                     + SUM_W'(share_reg[SHARE_NICE]);

    always_comb
    begin
        out_next = out_reg;
        if (cmd.emit)
        begin
            if (cmd.emit_short)
            begin
                out_next.user_share    = '0;
                out_next.system_share  = '0;
                out_next.nice_share    = '0;
                out_next.idle_share    = SHARE_SCALE;
                out_next.too_few_ticks = 1'b1;
            end
            else
            begin
                out_next.user_share    = share_reg[SHARE_USER];
                out_next.system_share  = share_reg[SHARE_SYSTEM];
                out_next.nice_share    = share_reg[SHARE_NICE];
                out_next.idle_share    = (share_sum >= SUM_W'(SHARE_SCALE)) ? '0 :
                                         SHARE_W'(SUM_W'(SHARE_SCALE) - share_sum);
                out_next.too_few_ticks = 1'b0;
            end
        end
    end

    // Previous counters and the configured minimum carry reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CNT; i++)
            begin
                prev_reg[i] <= '0;
            end
            min_reg <= MIN_TICKS_RESET;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int i = 0; i < NUM_CNT; i++)
                begin
                    prev_reg[i] <= in_cnt[i];
                end
            end
            if (cfg_wr)
            begin
                min_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < NUM_CNT; i++)
            begin
                delta_reg[i] <= in_cnt[i] - prev_reg[i];
            end
        end
        if (cmd.store)
        begin
            share_reg[cmd.lane] <= share_val;
        end
        total_reg <= total_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        quot_reg  <= quot_next;
        sat_reg   <= sat_next;
        out_reg   <= out_next;
    end

    assign result_data = out_reg;

endmodule

`default_nettype wire

@@ rtl/cpu_load_share_from_ticks.sv @@
// ----------------------------------------------------------------------------
// cpu_load_share_from_ticks: CPU load shares from cumulative tick counters
// Turns each sample of five cumulative tick counters into user, system, nice
// and idle shares in per-mille of the ticks elapsed since the last sample.
// ----------------------------------------------------------------------------
// Usage:
// - sample takes one item of five 64-bit counters when valid and ready are
//   both high; ready is high only while no sample is being worked on.
// - result presents one item of four shares and the too_few_ticks flag.
// - cfg writes min_total_ticks; it is always ready. The user must write it only
//   while the block is idle; the block itself does not enforce this.
// Sequence: the deltas are summed on one adder, the summed delta is checked
// against the minimum and, only when it exceeds the minimum, three shares are
// computed in turn on one multiply and ten-step restoring divide unit before
// the output write. A new sample is taken only after the previous one has
// reached the output register.
// The result sits in an output register: the next sample is accepted and
// worked on while it waits, and only its output write waits for the receiver.
// Reset clears the previous counters to zero, sets min_total_ticks to 10 and
// drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_load_share_from_ticks (
    input  logic           clk,
    input  logic           rst_n,
    clsft_stream_if.sink   sample,
    clsft_stream_if.source result,
    clsft_stream_if.sink   cfg
);
    import clsft_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    clsft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    clsft_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_data (sample.data),
        .result_data (result.data),
        .cfg_wr      (cfg.valid),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .status      (status)
    );

    // A sample being worked on holds ready low in the cycle after it is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample accepted back to back");

    // The too-few-ticks result carries zero shares and a full idle share.
    a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.too_few_ticks |->
            result.data.user_share == '0 && result.data.system_share == '0 &&
            result.data.nice_share == '0 && result.data.idle_share == SHARE_SCALE)
        else $error("malformed too-few-ticks result");

    // Shares add up to 1000 unless idle was clamped to zero.
    a_share_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            result.data.idle_share == '0 ||
            SUM_W'(result.data.user_share) + SUM_W'(result.data.system_share) +
            SUM_W'(result.data.nice_share) + SUM_W'(result.data.idle_share) ==
            SUM_W'(SHARE_SCALE))
        else $error("shares do not add up to 1000");

    // No user, system or nice share exceeds full scale.
    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            result.data.user_share <= SHARE_SCALE &&
            result.data.system_share <= SHARE_SCALE &&
            result.data.nice_share <= SHARE_SCALE)
        else $error("share above 1000");

endmodule

`default_nettype wire
